@@ hdl/clc_pkg.sv @@
// Shared types and constants for the character LCD text console.
// Holds command codes, the sequencer states and the text RAM control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

  // default and largest row length
  localparam int unsigned ColumnsDflt = 16;
  localparam int unsigned ColumnsMax  = 40;

  // address width of the text RAM control bus, sized for the largest buffer
  localparam int unsigned RamAddrW = $clog2(2 * ColumnsMax);

  // request modes of an input item
  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_INIT  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // display commands
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h3C;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_LINE1        = 8'h80;
  localparam logic [7:0] CMD_LINE2        = 8'hC0;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COPY = 5'b00010,
    ST_READ = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_SEND = 5'b10000
  } state_e;

  // sequencer to text RAM control
  typedef struct packed {
    logic                we;
    logic [RamAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic [RamAddrW-1:0] raddr;
    logic                clr_all;
    logic                clr_bot;
  } ram_ctl_t;

  // display set-up command sequence
  function automatic logic [7:0] init_cmd(input logic [1:0] step);
    logic [7:0] cmd;
    unique case (step)
      2'd0:    cmd = CMD_FUNCTION_SET;
      2'd1:    cmd = CMD_DISPLAY_ON;
      2'd2:    cmd = CMD_CLEAR;
      default: cmd = CMD_ENTRY_MODE;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

@@ hdl/clc_ifs.sv @@
// Valid/ready channel interfaces of the character LCD text console.
// clc_in_if carries request items, clc_out_if carries LCD write items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic       last_of_string;

  modport source (output valid, output mode, output char_code, output last_of_string,
                  input ready);
  modport sink   (input valid, input mode, input char_code, input last_of_string,
                  output ready);
endinterface

interface clc_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [7:0] lcd_byte;
  logic       last_write;

  modport source (output valid, output register_select, output lcd_byte, output last_write,
                  input ready);
  modport sink   (input valid, input register_select, input lcd_byte, input last_write,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/clc_text_ram.sv @@
// Two-row text buffer: one write port, one registered read port.
// Per-entry valid bits make unwritten or cleared entries read as a space.
// Depends on clc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clc_text_ram #(
  parameter int unsigned COLUMNS = clc_pkg::ColumnsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clc_pkg::ram_ctl_t ctl_i,
  output logic [7:0]        rd_byte_o
);
  import clc_pkg::*;

  localparam int unsigned Entries = 2 * COLUMNS;
  localparam int unsigned AW      = $clog2(Entries);

  logic [7:0]         mem_q [Entries];
  logic [Entries-1:0] valid_q, valid_d;
  logic [7:0]         rdata_q;
  logic               rvalid_q;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;

  assign waddr = ctl_i.waddr[AW-1:0];
  assign raddr = ctl_i.raddr[AW-1:0];

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr] <= ctl_i.wdata;
    end
    rdata_q  <= mem_q[raddr];
    rvalid_q <= valid_q[raddr];
  end

  // valid bits: clear whole buffer or bottom row, set on write
  always_comb begin
    valid_d = valid_q;
    for (int e = 0; e < Entries; e++) begin
      if (ctl_i.clr_all || (ctl_i.clr_bot && (e >= COLUMNS))) begin
        valid_d[e] = 1'b0;
      end else if (ctl_i.we && (waddr == AW'(e))) begin
        valid_d[e] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_byte_o = rvalid_q ? rdata_q : CH_SPACE;

endmodule

`default_nettype wire

@@ hdl/clc_seq.sv @@
// Console sequencer: edits the buffer, copies rows, and issues LCD writes
// through one shared step adder. Drives the text RAM through ram_ctl_t.
// Depends on clc_pkg and the clc_in_if / clc_out_if interfaces.
`timescale 1ns / 1ps
`default_nettype none

module clc_seq #(
  parameter int unsigned COLUMNS = clc_pkg::ColumnsDflt
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clc_in_if.sink            in_i,
  clc_out_if.source         out_o,
  output clc_pkg::ram_ctl_t ram_ctl_o,
  input  logic [7:0]        ram_byte_i
);
  import clc_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS + 1);
  localparam int unsigned IW = $clog2(2 * COLUMNS + 2);
  localparam int unsigned AW = $clog2(2 * COLUMNS);

  localparam logic [IW-1:0] IdxCols     = IW'(COLUMNS);
  localparam logic [IW-1:0] IdxLine2    = IW'(COLUMNS + 1);
  localparam logic [IW-1:0] IdxLast     = IW'(2 * COLUMNS + 1);
  localparam logic [IW-1:0] IdxInitLast = IW'(3);
  localparam logic [CW-1:0] ColMax      = CW'(COLUMNS);
  localparam logic [AW-1:0] AddrBot     = AW'(COLUMNS);

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] col_q, col_d;
  logic          pend_q, pend_d;
  logic          draw_q, draw_d;
  logic          init_q, init_d;
  logic          rs_q, rs_d;
  logic [7:0]    byte_q, byte_d;
  logic          last_q, last_d;

  logic          in_ready;
  ram_ctl_t      ram_ctl;

  // shared step adder: column steps in idle, index steps elsewhere
  logic [IW-1:0] unit_a, unit_b, unit_sum;

  // character decode
  logic [7:0]    code;
  logic          acts, is_nl, is_cr, is_bs, is_txt, col_lt, pend_now;
  logic [CW-1:0] bs_col;

  // redraw index decode
  logic          is_cmd;
  logic [IW-1:0] rd_off, rd_idx;

  assign code   = in_i.char_code;
  assign acts   = (code != 8'h00) && !code[7];
  assign is_nl  = acts && (code == CH_NEWLINE);
  assign is_cr  = acts && (code == CH_RETURN);
  assign is_bs  = acts && (code == CH_BACKSPACE);
  assign is_txt = acts && !is_nl && !is_cr && !is_bs;
  assign col_lt = col_q < ColMax;

  assign unit_a   = (state_q == ST_IDLE) ? IW'(col_q) : idx_q;
  assign unit_b   = ((state_q == ST_IDLE) && is_bs) ? '1 : IW'(1);
  assign unit_sum = unit_a + unit_b;

  assign bs_col = (col_q != '0) ? unit_sum[CW-1:0] : '0;

  assign is_cmd = (idx_q == '0) || (idx_q == IdxLine2);
  assign rd_off = (idx_q > IdxCols) ? IW'(2) : IW'(1);
  assign rd_idx = idx_q - rd_off;

  // sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    col_d    = col_q;
    pend_d   = pend_q;
    draw_d   = draw_q;
    init_d   = init_q;
    rs_d     = rs_q;
    byte_d   = byte_q;
    last_d   = last_q;
    ram_ctl  = '0;
    in_ready = 1'b0;
    pend_now = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          unique case (mode_e'(in_i.mode))
            MODE_INIT: begin
              col_d   = '0;
              init_d  = 1'b1;
              idx_d   = '0;
              state_d = ST_READ;
            end
            MODE_CLEAR: begin
              ram_ctl.clr_all = 1'b1;
            end
            MODE_CHAR: begin
              if (is_nl) begin
                // row copy runs first, redraw decided after it
                col_d   = '0;
                pend_d  = 1'b1;
                draw_d  = in_i.last_of_string;
                idx_d   = '0;
                state_d = ST_COPY;
              end else begin
                if (is_cr) begin
                  ram_ctl.clr_bot = 1'b1;
                  col_d           = '0;
                  pend_now        = 1'b1;
                end else if (is_bs) begin
                  ram_ctl.we    = 1'b1;
                  ram_ctl.waddr = RamAddrW'(AddrBot + AW'(bs_col));
                  ram_ctl.wdata = CH_SPACE;
                  col_d         = bs_col;
                  pend_now      = 1'b1;
                end else if (is_txt && col_lt) begin
                  ram_ctl.we    = 1'b1;
                  ram_ctl.waddr = RamAddrW'(AddrBot + AW'(col_q));
                  ram_ctl.wdata = code;
                  col_d         = unit_sum[CW-1:0];
                  pend_now      = 1'b1;
                end
                if (in_i.last_of_string && (pend_q || pend_now)) begin
                  pend_d  = 1'b0;
                  init_d  = 1'b0;
                  idx_d   = '0;
                  state_d = ST_READ;
                end else begin
                  pend_d = pend_q || pend_now;
                end
              end
            end
            MODE_NONE: begin
            end
          endcase
        end
      end

      ST_COPY: begin
        // read bottom[idx], write top[idx-1] from the previous read
        if (idx_q < IdxCols) begin
          ram_ctl.raddr = RamAddrW'(AddrBot + AW'(idx_q));
        end
        if (idx_q != '0) begin
          ram_ctl.we    = 1'b1;
          ram_ctl.waddr = RamAddrW'(AW'(idx_q - IW'(1)));
          ram_ctl.wdata = ram_byte_i;
        end
        if (idx_q == IdxCols) begin
          ram_ctl.clr_bot = 1'b1;
          if (draw_q) begin
            pend_d  = 1'b0;
            init_d  = 1'b0;
            idx_d   = '0;
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          idx_d = unit_sum;
        end
      end

      ST_READ: begin
        if (!init_q && !is_cmd) begin
          ram_ctl.raddr = RamAddrW'(AW'(rd_idx));
        end
        state_d = ST_LOAD;
      end

      ST_LOAD: begin
        if (init_q) begin
          rs_d   = 1'b0;
          byte_d = init_cmd(idx_q[1:0]);
          last_d = (idx_q == IdxInitLast);
        end else begin
          rs_d   = !is_cmd;
          byte_d = (idx_q == '0) ? CMD_LINE1 : (is_cmd ? CMD_LINE2 : ram_byte_i);
          last_d = (idx_q == IdxLast);
        end
        state_d = ST_SEND;
      end

      ST_SEND: begin
        if (out_o.ready) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = unit_sum;
            state_d = ST_READ;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      col_q   <= '0;
      pend_q  <= 1'b0;
      draw_q  <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      pend_q  <= pend_d;
      draw_q  <= draw_d;
      init_q  <= init_d;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = (state_q == ST_SEND);
  assign out_o.register_select = rs_q;
  assign out_o.lcd_byte        = byte_q;
  assign out_o.last_write      = last_q;
  assign ram_ctl_o             = ram_ctl;

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !out_o.valid)
    else $error("input ready while an output item is pending");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= ColMax)
    else $error("cursor column beyond row length");

  a_copy_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && idx_q == IdxCols && draw_q) |=> (state_q == ST_READ && !pend_q))
    else $error("redraw after row copy did not start or left pending set");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && last_q) |=> in_ready)
    else $error("not ready after the final write of a run");

endmodule

`default_nettype wire

@@ hdl/char_lcd_text_console.sv @@
// Two-row text console for a character LCD: a sequencer and its text RAM.
// Depends on clc_pkg, clc_ifs, clc_text_ram and clc_seq.
//
// Items arrive on in_i; LCD register writes leave on out_o, one item per write,
// last_write marking the end of a run. A character edit, carriage return or
// clear is done as the item is accepted; a newline first copies the bottom
// row up to the top row through the RAM read and write ports. Each LCD write
// passes through address, RAM read and output register steps, then waits on
// out_o.ready, so a full redraw is 2*COLUMNS+2 writes and init is four. Input
// is not accepted until a run finishes. The buffer comes out of reset as all
// spaces with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_text_console #(
  parameter int unsigned COLUMNS = clc_pkg::ColumnsDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clc_in_if.sink    in_i,
  clc_out_if.source out_o
);
  import clc_pkg::*;

  ram_ctl_t   ram_ctl;
  logic [7:0] ram_byte;

  // sequencer
  clc_seq #(
    .COLUMNS (COLUMNS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .ram_ctl_o  (ram_ctl),
    .ram_byte_i (ram_byte)
  );

  // text buffer
  clc_text_ram #(
    .COLUMNS (COLUMNS)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ram_ctl),
    .rd_byte_o (ram_byte)
  );

endmodule

`default_nettype wire
